// ----- rtl/qvr_pkg.sv -----
// ----------------------------------------------------------------------------
// qvr_pkg
// Shared types and constants of the quaternion vector rotation pipeline.
// ----------------------------------------------------------------------------
package qvr_pkg;

  // Field format of every vector and quaternion component.
  localparam int WORD_W = 32;
  typedef logic signed [WORD_W-1:0] word_t;

  // The unit quaternion is carried in Q2.28.
  localparam int UNIT_SHIFT = 28;
  localparam longint ROUND_HALF = 64'sd1 <<< (UNIT_SHIFT - 1);

  // Internal widths.
  localparam int MAG_W    = 32;   // |component|, up to 2^31
  localparam int SMAG_W   = 31;   // prescaled magnitude, up to 2^30
  localparam int SQ_W     = 62;   // square of a prescaled magnitude
  localparam int N_W      = 64;   // sum of squares and root working width
  localparam int ROOT_W   = 32;   // floor of the square root
  localparam int ROOT_STEPS = 32;
  localparam int QUO_W    = 29;   // unsigned unit component, up to 2^28
  localparam int DIV_W    = 62;   // partial remainder of the normalize divide
  localparam int DVS_W    = ROOT_W + 1;
  localparam int UNIT_W   = 30;   // signed unit component
  localparam int PROD1_W  = 62;
  localparam int SUM1_W   = 64;
  localparam int P_W      = 36;   // first Hamilton product, rounded
  localparam int PROD2_W  = 66;
  localparam int SUM2_W   = 68;
  localparam int R_W      = 40;   // second product, rounded, before clamping
  localparam int SHIFT_W  = 5;

  typedef logic [SMAG_W-1:0]        smag_t;
  typedef logic signed [UNIT_W-1:0] unit_t;
  typedef logic signed [P_W-1:0]    pvec_t;

  // Side data that rides along the length and divide stages.
  typedef struct packed {
    smag_t [3:0] mag;
    logic  [3:0] neg;
    word_t [2:0] vec;
    logic        degen;
  } side_t;

endpackage

// ----- rtl/qvr_stream_if.sv -----
// ----------------------------------------------------------------------------
// qvr_in_if / qvr_out_if
// Valid/ready channels that carry one rotation request and one result.
// ----------------------------------------------------------------------------
interface qvr_in_if;
  logic           valid;
  logic           ready;
  qvr_pkg::word_t quat_i;
  qvr_pkg::word_t quat_j;
  qvr_pkg::word_t quat_k;
  qvr_pkg::word_t quat_w;
  qvr_pkg::word_t vec_x;
  qvr_pkg::word_t vec_y;
  qvr_pkg::word_t vec_z;

  modport source (output valid, quat_i, quat_j, quat_k, quat_w, vec_x, vec_y, vec_z,
                  input ready);
  modport sink   (input valid, quat_i, quat_j, quat_k, quat_w, vec_x, vec_y, vec_z,
                  output ready);
endinterface

interface qvr_out_if;
  logic           valid;
  logic           ready;
  qvr_pkg::word_t rot_x;
  qvr_pkg::word_t rot_y;
  qvr_pkg::word_t rot_z;
  logic           degenerate;
  logic           saturated;

  modport source (output valid, rot_x, rot_y, rot_z, degenerate, saturated,
                  input ready);
  modport sink   (input valid, rot_x, rot_y, rot_z, degenerate, saturated,
                  output ready);
endinterface

// ----- rtl/quaternion_vector_rotate.sv -----
// ----------------------------------------------------------------------------
// quaternion_vector_rotate
// Rotates a Q16.16 vector by a quaternion that is normalized on the fly.
// ----------------------------------------------------------------------------
// One transaction enters per clock unless the sink stalls; the pipeline
// advances as a whole whenever the output register is empty or being
// taken, so a stalled sink freezes every stage and nothing is lost. The depth
// is set by the 32 one-bit steps of the square root that finds the quaternion
// length and by the 29 one-bit steps of the divides that scale each component
// to unit length (four dividers run side by side). The quaternion is first
// prescaled by a power of two so its largest magnitude lies in [2^29, 2^30],
// which leaves the rotation unchanged. A zero quaternion passes the vector
// through unchanged with degenerate set; results that leave the 32-bit range
// are clamped with saturated set. Rounding is to nearest, ties away from zero.
// ----------------------------------------------------------------------------
module quaternion_vector_rotate (
  input  logic     clk,
  input  logic     rst_n,
  qvr_in_if.sink   in_chan,
  qvr_out_if.source out_chan
);

  localparam int DIV_STEPS = qvr_pkg::QUO_W;
  localparam logic signed [qvr_pkg::R_W-1:0] R_MAX = 40'sd2147483647;
  localparam logic signed [qvr_pkg::R_W-1:0] R_MIN = -40'sd2147483648;

  logic adv;
  logic out_valid_r;

  // The whole pipeline moves when the output slot is free or being emptied.
  assign adv           = !out_valid_r || out_chan.ready;
  assign in_chan.ready = adv;

  // --------------------------------------------------------------------------
  // Stage 1: magnitudes, signs and the largest magnitude.
  // --------------------------------------------------------------------------
  logic [qvr_pkg::MAG_W-1:0] s1_mag_r [4];
  logic [qvr_pkg::MAG_W-1:0] s1_m_r;
  logic [3:0]                s1_neg_r;
  qvr_pkg::word_t [2:0]      s1_vec_r;
  logic                      s1_valid_r;

  logic [qvr_pkg::MAG_W-1:0] s1_mag_nxt [4];
  logic [qvr_pkg::MAG_W-1:0] s1_m_nxt;
  qvr_pkg::word_t            qin [4];

  always_comb begin
    logic [qvr_pkg::MAG_W-1:0] m01;
    logic [qvr_pkg::MAG_W-1:0] m23;
    qin[0] = in_chan.quat_i;
    qin[1] = in_chan.quat_j;
    qin[2] = in_chan.quat_k;
    qin[3] = in_chan.quat_w;
    for (int c = 0; c < 4; c++) begin
      s1_mag_nxt[c] = qin[c][qvr_pkg::WORD_W-1] ? (~qin[c] + 1'b1) : qin[c];
    end
    m01 = (s1_mag_nxt[0] > s1_mag_nxt[1]) ? s1_mag_nxt[0] : s1_mag_nxt[1];
    m23 = (s1_mag_nxt[2] > s1_mag_nxt[3]) ? s1_mag_nxt[2] : s1_mag_nxt[3];
    s1_m_nxt = (m01 > m23) ? m01 : m23;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (adv) begin
      s1_valid_r <= in_chan.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      for (int c = 0; c < 4; c++) begin
        s1_mag_r[c] <= s1_mag_nxt[c];
        s1_neg_r[c] <= qin[c][qvr_pkg::WORD_W-1];
      end
      s1_m_r      <= s1_m_nxt;
      s1_vec_r[0] <= in_chan.vec_x;
      s1_vec_r[1] <= in_chan.vec_y;
      s1_vec_r[2] <= in_chan.vec_z;
    end
  end

  // --------------------------------------------------------------------------
  // Stage 2: prescale decision. Large quaternions are halved once, small ones
  // are shifted left until the leading one reaches bit 29.
  // --------------------------------------------------------------------------
  logic [qvr_pkg::MAG_W-1:0]   s2_mag_r [4];
  logic [3:0]                  s2_neg_r;
  qvr_pkg::word_t [2:0]        s2_vec_r;
  logic [qvr_pkg::SHIFT_W-1:0] s2_sh_r;
  logic                        s2_big_r;
  logic                        s2_degen_r;
  logic                        s2_valid_r;
  logic [qvr_pkg::SHIFT_W-1:0] s2_sh_nxt;

  always_comb begin
    logic [qvr_pkg::SHIFT_W-1:0] msb;
    msb = '0;
    for (int i = 0; i < 30; i++) begin
      if (s1_m_r[i]) begin
        msb = qvr_pkg::SHIFT_W'(i);
      end
    end
    s2_sh_nxt = qvr_pkg::SHIFT_W'(29) - msb;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_valid_r <= 1'b0;
    end else if (adv) begin
      s2_valid_r <= s1_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s2_mag_r   <= s1_mag_r;
      s2_neg_r   <= s1_neg_r;
      s2_vec_r   <= s1_vec_r;
      s2_sh_r    <= s2_sh_nxt;
      s2_big_r   <= s1_m_r[31] | s1_m_r[30];
      s2_degen_r <= (s1_m_r == '0);
    end
  end

  // --------------------------------------------------------------------------
  // Stage 3: apply the prescale.
  // --------------------------------------------------------------------------
  qvr_pkg::side_t s3_side_r;
  qvr_pkg::side_t s3_side_nxt;
  logic           s3_valid_r;

  always_comb begin
    for (int c = 0; c < 4; c++) begin
      if (s2_big_r) begin
        s3_side_nxt.mag[c] = qvr_pkg::SMAG_W'((33'(s2_mag_r[c]) + 33'd1) >> 1);
      end else begin
        s3_side_nxt.mag[c] = qvr_pkg::SMAG_W'(s2_mag_r[c] << s2_sh_r);
      end
    end
    s3_side_nxt.neg   = s2_neg_r;
    s3_side_nxt.vec   = s2_vec_r;
    s3_side_nxt.degen = s2_degen_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s3_valid_r <= 1'b0;
    end else if (adv) begin
      s3_valid_r <= s2_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s3_side_r <= s3_side_nxt;
    end
  end

  // --------------------------------------------------------------------------
  // Stage 4: squares. Stage 5: their sum, the squared length.
  // --------------------------------------------------------------------------
  logic [qvr_pkg::SQ_W-1:0] s4_sq_r [4];
  qvr_pkg::side_t           s4_side_r;
  logic                     s4_valid_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s4_valid_r <= 1'b0;
    end else if (adv) begin
      s4_valid_r <= s3_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      for (int c = 0; c < 4; c++) begin
        s4_sq_r[c] <= qvr_pkg::SQ_W'(s3_side_r.mag[c]) * qvr_pkg::SQ_W'(s3_side_r.mag[c]);
      end
      s4_side_r <= s3_side_r;
    end
  end

  // Square root chain: index 0 holds the sum, index t+1 the state after step t.
  logic [qvr_pkg::N_W-1:0] rt_n_r    [qvr_pkg::ROOT_STEPS+1];
  logic [qvr_pkg::N_W-1:0] rt_res_r  [qvr_pkg::ROOT_STEPS+1];
  qvr_pkg::side_t          rt_side_r [qvr_pkg::ROOT_STEPS+1];
  logic                    rt_valid_r [qvr_pkg::ROOT_STEPS+1];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rt_valid_r[0] <= 1'b0;
    end else if (adv) begin
      rt_valid_r[0] <= s4_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      rt_n_r[0]    <= qvr_pkg::N_W'(s4_sq_r[0]) + qvr_pkg::N_W'(s4_sq_r[1])
                    + qvr_pkg::N_W'(s4_sq_r[2]) + qvr_pkg::N_W'(s4_sq_r[3]);
      rt_res_r[0]  <= '0;
      rt_side_r[0] <= s4_side_r;
    end
  end

  // --------------------------------------------------------------------------
  // Integer square root, one result bit per stage.
  // --------------------------------------------------------------------------
  for (genvar t = 0; t < qvr_pkg::ROOT_STEPS; t++) begin : g_root
    localparam logic [qvr_pkg::N_W-1:0] BITV = qvr_pkg::N_W'(1) << (62 - 2 * t);
    logic [qvr_pkg::N_W-1:0] trial;
    logic [qvr_pkg::N_W-1:0] n_nxt;
    logic [qvr_pkg::N_W-1:0] res_nxt;

    always_comb begin
      trial = rt_res_r[t] + BITV;
      if (rt_n_r[t] >= trial) begin
        n_nxt   = rt_n_r[t] - trial;
        res_nxt = (rt_res_r[t] >> 1) + BITV;
      end else begin
        n_nxt   = rt_n_r[t];
        res_nxt = rt_res_r[t] >> 1;
      end
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        rt_valid_r[t+1] <= 1'b0;
      end else if (adv) begin
        rt_valid_r[t+1] <= rt_valid_r[t];
      end
    end

    always_ff @(posedge clk) begin
      if (adv) begin
        rt_n_r[t+1]    <= n_nxt;
        rt_res_r[t+1]  <= res_nxt;
        rt_side_r[t+1] <= rt_side_r[t];
      end
    end
  end

  // --------------------------------------------------------------------------
  // Normalize: u = round(mag * 2^28 / s) as (mag * 2^29 + s) / (2 s), four
  // restoring dividers in step, one quotient bit per stage, top bit first.
  // --------------------------------------------------------------------------
  logic [3:0][qvr_pkg::DIV_W-1:0] dv_rem_r  [DIV_STEPS+1];
  logic [3:0][qvr_pkg::QUO_W-1:0] dv_q_r    [DIV_STEPS+1];
  logic [qvr_pkg::DVS_W-1:0]      dv_d_r    [DIV_STEPS+1];
  qvr_pkg::side_t                 dv_side_r [DIV_STEPS+1];
  logic                           dv_valid_r [DIV_STEPS+1];

  logic [qvr_pkg::ROOT_W-1:0] root;
  assign root = rt_res_r[qvr_pkg::ROOT_STEPS][qvr_pkg::ROOT_W-1:0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dv_valid_r[0] <= 1'b0;
    end else if (adv) begin
      dv_valid_r[0] <= rt_valid_r[qvr_pkg::ROOT_STEPS];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      for (int c = 0; c < 4; c++) begin
        dv_rem_r[0][c] <= (qvr_pkg::DIV_W'(rt_side_r[qvr_pkg::ROOT_STEPS].mag[c])
                           << (qvr_pkg::UNIT_SHIFT + 1)) + qvr_pkg::DIV_W'(root);
        dv_q_r[0][c]   <= '0;
      end
      dv_d_r[0]    <= {root, 1'b0};
      dv_side_r[0] <= rt_side_r[qvr_pkg::ROOT_STEPS];
    end
  end

  for (genvar t = 0; t < DIV_STEPS; t++) begin : g_div
    localparam int B = DIV_STEPS - 1 - t;
    logic [qvr_pkg::DIV_W-1:0]      trial;
    logic [3:0][qvr_pkg::DIV_W-1:0] rem_nxt;
    logic [3:0][qvr_pkg::QUO_W-1:0] q_nxt;

    always_comb begin
      trial = qvr_pkg::DIV_W'(dv_d_r[t]) << B;
      for (int c = 0; c < 4; c++) begin
        if (dv_rem_r[t][c] >= trial) begin
          rem_nxt[c] = dv_rem_r[t][c] - trial;
          q_nxt[c]   = dv_q_r[t][c] | (qvr_pkg::QUO_W'(1) << B);
        end else begin
          rem_nxt[c] = dv_rem_r[t][c];
          q_nxt[c]   = dv_q_r[t][c];
        end
      end
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        dv_valid_r[t+1] <= 1'b0;
      end else if (adv) begin
        dv_valid_r[t+1] <= dv_valid_r[t];
      end
    end

    always_ff @(posedge clk) begin
      if (adv) begin
        dv_rem_r[t+1]  <= rem_nxt;
        dv_q_r[t+1]    <= q_nxt;
        dv_d_r[t+1]    <= dv_d_r[t];
        dv_side_r[t+1] <= dv_side_r[t];
      end
    end
  end

  // --------------------------------------------------------------------------
  // Signed unit quaternion.
  // --------------------------------------------------------------------------
  qvr_pkg::unit_t       un_u_r [4];
  qvr_pkg::word_t [2:0] un_vec_r;
  logic                 un_degen_r;
  logic                 un_valid_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      un_valid_r <= 1'b0;
    end else if (adv) begin
      un_valid_r <= dv_valid_r[DIV_STEPS];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      for (int c = 0; c < 4; c++) begin
        if (dv_side_r[DIV_STEPS].neg[c]) begin
          un_u_r[c] <= -$signed({1'b0, dv_q_r[DIV_STEPS][c]});
        end else begin
          un_u_r[c] <= $signed({1'b0, dv_q_r[DIV_STEPS][c]});
        end
      end
      un_vec_r   <= dv_side_r[DIV_STEPS].vec;
      un_degen_r <= dv_side_r[DIV_STEPS].degen;
    end
  end

  // --------------------------------------------------------------------------
  // First Hamilton product p = u * (v, 0): products, sums, rounding.
  // Component order is i, j, k, w for u and x, y, z for v.
  // --------------------------------------------------------------------------
  logic signed [qvr_pkg::PROD1_W-1:0] h1_prod_r [4][3];
  qvr_pkg::unit_t                     h1_u_r [4];
  qvr_pkg::word_t [2:0]               h1_vec_r;
  logic                               h1_degen_r;
  logic                               h1_valid_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      h1_valid_r <= 1'b0;
    end else if (adv) begin
      h1_valid_r <= un_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      for (int c = 0; c < 4; c++) begin
        for (int d = 0; d < 3; d++) begin
          h1_prod_r[c][d] <= qvr_pkg::PROD1_W'(un_u_r[c]) * qvr_pkg::PROD1_W'(un_vec_r[d]);
        end
      end
      h1_u_r     <= un_u_r;
      h1_vec_r   <= un_vec_r;
      h1_degen_r <= un_degen_r;
    end
  end

  logic signed [qvr_pkg::SUM1_W-1:0] h1_sum_r [4];
  qvr_pkg::unit_t                    h1s_u_r [4];
  qvr_pkg::word_t [2:0]              h1s_vec_r;
  logic                              h1s_degen_r;
  logic                              h1s_valid_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      h1s_valid_r <= 1'b0;
    end else if (adv) begin
      h1s_valid_r <= h1_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      h1_sum_r[0] <=  qvr_pkg::SUM1_W'(h1_prod_r[1][2]) - qvr_pkg::SUM1_W'(h1_prod_r[2][1])
                    + qvr_pkg::SUM1_W'(h1_prod_r[3][0]);
      h1_sum_r[1] <= -qvr_pkg::SUM1_W'(h1_prod_r[0][2]) + qvr_pkg::SUM1_W'(h1_prod_r[2][0])
                    + qvr_pkg::SUM1_W'(h1_prod_r[3][1]);
      h1_sum_r[2] <=  qvr_pkg::SUM1_W'(h1_prod_r[0][1]) - qvr_pkg::SUM1_W'(h1_prod_r[1][0])
                    + qvr_pkg::SUM1_W'(h1_prod_r[3][2]);
      h1_sum_r[3] <= -qvr_pkg::SUM1_W'(h1_prod_r[0][0]) - qvr_pkg::SUM1_W'(h1_prod_r[1][1])
                    - qvr_pkg::SUM1_W'(h1_prod_r[2][2]);
      h1s_u_r     <= h1_u_r;
      h1s_vec_r   <= h1_vec_r;
      h1s_degen_r <= h1_degen_r;
    end
  end

  // Rounding to nearest with ties away from zero: negative values take a bias
  // one smaller before the arithmetic shift.
  qvr_pkg::pvec_t       h1r_p_r [4];
  qvr_pkg::unit_t       h1r_u_r [4];
  qvr_pkg::word_t [2:0] h1r_vec_r;
  logic                 h1r_degen_r;
  logic                 h1r_valid_r;
  qvr_pkg::pvec_t       h1r_p_nxt [4];

  always_comb begin
    logic signed [qvr_pkg::SUM1_W-1:0] bias;
    for (int c = 0; c < 4; c++) begin
      bias = qvr_pkg::SUM1_W'(qvr_pkg::ROUND_HALF);
      if (h1_sum_r[c] < 0) begin
        bias = bias - qvr_pkg::SUM1_W'(64'sd1);
      end
      h1r_p_nxt[c] = qvr_pkg::P_W'((h1_sum_r[c] + bias) >>> qvr_pkg::UNIT_SHIFT);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      h1r_valid_r <= 1'b0;
    end else if (adv) begin
      h1r_valid_r <= h1s_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      h1r_p_r     <= h1r_p_nxt;
      h1r_u_r     <= h1s_u_r;
      h1r_vec_r   <= h1s_vec_r;
      h1r_degen_r <= h1s_degen_r;
    end
  end

  // --------------------------------------------------------------------------
  // Second Hamilton product r = p * conj(u): products, sums, rounding.
  // --------------------------------------------------------------------------
  logic signed [qvr_pkg::PROD2_W-1:0] h2_prod_r [4][4];
  qvr_pkg::word_t [2:0]               h2_vec_r;
  logic                               h2_degen_r;
  logic                               h2_valid_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      h2_valid_r <= 1'b0;
    end else if (adv) begin
      h2_valid_r <= h1r_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      for (int a = 0; a < 4; a++) begin
        for (int b = 0; b < 4; b++) begin
          h2_prod_r[a][b] <= qvr_pkg::PROD2_W'(h1r_p_r[a]) * qvr_pkg::PROD2_W'(h1r_u_r[b]);
        end
      end
      h2_vec_r   <= h1r_vec_r;
      h2_degen_r <= h1r_degen_r;
    end
  end

  logic signed [qvr_pkg::SUM2_W-1:0] h2_sum_r [3];
  qvr_pkg::word_t [2:0]              h2s_vec_r;
  logic                              h2s_degen_r;
  logic                              h2s_valid_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      h2s_valid_r <= 1'b0;
    end else if (adv) begin
      h2s_valid_r <= h2_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      h2_sum_r[0] <=  qvr_pkg::SUM2_W'(h2_prod_r[0][3]) - qvr_pkg::SUM2_W'(h2_prod_r[1][2])
                    + qvr_pkg::SUM2_W'(h2_prod_r[2][1]) - qvr_pkg::SUM2_W'(h2_prod_r[3][0]);
      h2_sum_r[1] <=  qvr_pkg::SUM2_W'(h2_prod_r[0][2]) + qvr_pkg::SUM2_W'(h2_prod_r[1][3])
                    - qvr_pkg::SUM2_W'(h2_prod_r[2][0]) - qvr_pkg::SUM2_W'(h2_prod_r[3][1]);
      h2_sum_r[2] <= -qvr_pkg::SUM2_W'(h2_prod_r[0][1]) + qvr_pkg::SUM2_W'(h2_prod_r[1][0])
                    + qvr_pkg::SUM2_W'(h2_prod_r[2][3]) - qvr_pkg::SUM2_W'(h2_prod_r[3][2]);
      h2s_vec_r   <= h2_vec_r;
      h2s_degen_r <= h2_degen_r;
    end
  end

  logic signed [qvr_pkg::R_W-1:0] h2r_r_r [3];
  qvr_pkg::word_t [2:0]           h2r_vec_r;
  logic                           h2r_degen_r;
  logic                           h2r_valid_r;
  logic signed [qvr_pkg::R_W-1:0] h2r_r_nxt [3];

  always_comb begin
    logic signed [qvr_pkg::SUM2_W-1:0] bias;
    for (int c = 0; c < 3; c++) begin
      bias = qvr_pkg::SUM2_W'(qvr_pkg::ROUND_HALF);
      if (h2_sum_r[c] < 0) begin
        bias = bias - qvr_pkg::SUM2_W'(64'sd1);
      end
      h2r_r_nxt[c] = qvr_pkg::R_W'((h2_sum_r[c] + bias) >>> qvr_pkg::UNIT_SHIFT);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      h2r_valid_r <= 1'b0;
    end else if (adv) begin
      h2r_valid_r <= h2s_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      h2r_r_r     <= h2r_r_nxt;
      h2r_vec_r   <= h2s_vec_r;
      h2r_degen_r <= h2s_degen_r;
    end
  end

  // --------------------------------------------------------------------------
  // Output register: clamp to 32 bits, or pass the vector through when the
  // quaternion was zero.
  // --------------------------------------------------------------------------
  qvr_pkg::word_t [2:0] rot_nxt;
  logic                 sat_nxt;
  qvr_pkg::word_t [2:0] out_rot_r;
  logic                 out_degen_r;
  logic                 out_sat_r;

  always_comb begin
    sat_nxt = 1'b0;
    for (int c = 0; c < 3; c++) begin
      if (h2r_r_r[c] > R_MAX) begin
        rot_nxt[c] = qvr_pkg::WORD_W'(R_MAX);
        sat_nxt    = 1'b1;
      end else if (h2r_r_r[c] < R_MIN) begin
        rot_nxt[c] = qvr_pkg::WORD_W'(R_MIN);
        sat_nxt    = 1'b1;
      end else begin
        rot_nxt[c] = qvr_pkg::WORD_W'(h2r_r_r[c]);
      end
    end
    if (h2r_degen_r) begin
      rot_nxt = h2r_vec_r;
      sat_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (adv) begin
      out_valid_r <= h2r_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      out_rot_r   <= rot_nxt;
      out_degen_r <= h2r_degen_r;
      out_sat_r   <= sat_nxt;
    end
  end

  assign out_chan.valid      = out_valid_r;
  assign out_chan.rot_x      = out_rot_r[0];
  assign out_chan.rot_y      = out_rot_r[1];
  assign out_chan.rot_z      = out_rot_r[2];
  assign out_chan.degenerate = out_degen_r;
  assign out_chan.saturated  = out_sat_r;

endmodule
